// File: rtl/lmfd_pkg.sv
package lmfd_pkg;

	// Frame buffer geometry and command sequencing.
	localparam int ROWS_DEF  = 8;
	localparam int PIX_W     = 8;
	localparam int IDX_W     = 4;
	localparam int INIT_HEAD = 5;

	// Serial frame: an address byte then a data byte.
	localparam int ADDR_W  = 4;
	localparam int FRAME_W = 16;
	localparam int CNT_W   = 4;

	// Configuration port.
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 4;
	localparam int INT_W      = 4;
	localparam int SCAN_W     = 3;

	localparam logic [CFG_IDX_W-1:0] CFG_INTENSITY  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SCAN_LIMIT = 2'd1;

	localparam logic [INT_W-1:0]  INTENSITY_RST  = 4'd1;
	localparam logic [SCAN_W-1:0] SCAN_LIMIT_RST = 3'd7;

	// Controller register addresses.
	localparam logic [ADDR_W-1:0] ADDR_DECODE    = 4'h9;
	localparam logic [ADDR_W-1:0] ADDR_INTENSITY = 4'hA;
	localparam logic [ADDR_W-1:0] ADDR_SCANLIM   = 4'hB;
	localparam logic [ADDR_W-1:0] ADDR_SHUTDOWN  = 4'hC;
	localparam logic [ADDR_W-1:0] ADDR_TEST      = 4'hF;
	localparam logic [PIX_W-1:0]  MSB_MASK       = 8'h80;

	typedef enum logic [1:0] {
		FUNC_INIT    = 2'd0,
		FUNC_PIXEL   = 2'd1,
		FUNC_LOAD    = 2'd2,
		FUNC_REFRESH = 2'd3
	} func_t;

	typedef enum logic [1:0] {
		OP_CLEAR  = 2'd0,
		OP_SET    = 2'd1,
		OP_TOGGLE = 2'd2
	} pix_op_t;

	typedef enum logic {
		ST_IDLE = 1'b0,
		ST_RUN  = 1'b1
	} seq_state_t;

	// Buffer update request from the sequencer.
	typedef struct packed {
		logic             en;
		logic             pixel;
		logic [2:0]       row;
		logic [2:0]       column;
		logic [1:0]       op;
		logic [PIX_W-1:0] bits;
	} fb_wr_t;

	// One register frame handed to the serialiser.
	typedef struct packed {
		logic [ADDR_W-1:0] addr;
		logic [PIX_W-1:0]  data;
		logic              last;
	} frame_t;

endpackage

// File: rtl/led_matrix_frame_driver_core.sv
// Channel   Dir  Fields (lowest bit up)                                    Handshake
// s_*       in   tdata: func[1:0] row[4:2] column[7:5] pixel_op[9:8]       tvalid/tready
//                       row_bits[17:10], zero to 24 bits
// m_*       out  tdata: reg_addr[3:0] reg_data[11:4], zero to 16 bits;     tvalid/tready
//                tlast: last frame of a command
// cfg_*     in   cfg_index, cfg_data (0 intensity, 1 scan limit)           cfg_valid/cfg_ready
//
// Pixel and load-row words update the frame buffer and produce no frames.
// Each frame is shifted one bit per cycle; initialize yields 5 + ROWS frames, refresh ROWS.
// The first frame of a run reaches the output through the sequencer state register,
// the shift register and the output register.
// A new input word is taken once the last frame of a run is loaded into the shifter,
// while that frame is still shifting.
// A stalled output holds its word while the next frame is already shifting.
// Reset clears the frame buffer and loads intensity 1 and scan limit 7.
module led_matrix_frame_driver_core
	import lmfd_pkg::*;
#(
	parameter int ROWS = ROWS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [23:0]           s_tdata,  // func, row, column, pixel_op, row_bits
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [15:0]           m_tdata,  // reg_addr, reg_data
	output logic                  m_tlast,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	localparam int ROW_W = (ROWS > 1) ? $clog2(ROWS) : 1;

	fb_wr_t                  fb_wr;
	logic [ROW_W-1:0]        fb_rd_row;
	logic [PIX_W-1:0]        fb_rd_data;
	logic                    frm_valid;
	logic                    frm_ready;
	frame_t                  frm;
	logic [ADDR_W+PIX_W-1:0] out_data;

	// Registers may be written at any time the block is idle.
	assign cfg_ready = 1'b1;

	lmfd_seq #(.ROWS(ROWS)) u_seq (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_tvalid),
		.in_ready   (s_tready),
		.func       (s_tdata[1:0]),
		.row        (s_tdata[4:2]),
		.column     (s_tdata[7:5]),
		.pixel_op   (s_tdata[9:8]),
		.row_bits   (s_tdata[17:10]),
		.cfg_valid  (cfg_valid),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.fb_wr      (fb_wr),
		.fb_rd_row  (fb_rd_row),
		.fb_rd_data (fb_rd_data),
		.frm_valid  (frm_valid),
		.frm_ready  (frm_ready),
		.frm        (frm)
	);

	lmfd_fbuf #(.ROWS(ROWS)) u_fbuf (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr      (fb_wr),
		.rd_row  (fb_rd_row),
		.rd_data (fb_rd_data)
	);

	lmfd_ser u_ser (
		.clk       (clk),
		.arst_n    (arst_n),
		.frm_valid (frm_valid),
		.frm_ready (frm_ready),
		.frm       (frm),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_data  (out_data),
		.out_last  (m_tlast)
	);

	assign m_tdata = {4'b0, out_data};

endmodule

// File: rtl/lmfd_fbuf.sv
module lmfd_fbuf
	import lmfd_pkg::*;
#(
	parameter int ROWS = ROWS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  fb_wr_t                              wr,
	input  logic [((ROWS > 1) ? $clog2(ROWS) : 1)-1:0] rd_row,
	output logic [PIX_W-1:0]                    rd_data
);

	localparam int ROW_W = (ROWS > 1) ? $clog2(ROWS) : 1;

	logic [PIX_W-1:0] rows_q [ROWS];
	logic             in_range;
	logic [ROW_W-1:0] wr_row;
	logic [PIX_W-1:0] mask;
	logic [PIX_W-1:0] cur;
	logic [PIX_W-1:0] upd;

	// Rows at or beyond the buffer depth are ignored.
	assign in_range = ({1'b0, wr.row} < 4'(ROWS));
	assign wr_row   = wr.row[ROW_W-1:0];
	assign mask     = MSB_MASK >> wr.column;
	assign cur      = rows_q[wr_row];
	assign rd_data  = rows_q[rd_row];

	always_comb begin
		if (!wr.pixel) begin
			upd = wr.bits;
		end else begin
			case (wr.op)
				OP_CLEAR: upd = cur & ~mask;
				OP_SET:   upd = cur | mask;
				default:  upd = cur ^ mask;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < ROWS; i++) rows_q[i] <= '0;
		end else if (wr.en && in_range) begin
			rows_q[wr_row] <= upd;
		end
	end

endmodule

// File: rtl/lmfd_seq.sv
module lmfd_seq
	import lmfd_pkg::*;
#(
	parameter int ROWS = ROWS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic [1:0]                          func,
	input  logic [2:0]                          row,
	input  logic [2:0]                          column,
	input  logic [1:0]                          pixel_op,
	input  logic [PIX_W-1:0]                    row_bits,
	input  logic                                cfg_valid,
	input  logic [CFG_IDX_W-1:0]                cfg_index,
	input  logic [CFG_DATA_W-1:0]               cfg_data,
	output fb_wr_t                              fb_wr,
	output logic [((ROWS > 1) ? $clog2(ROWS) : 1)-1:0] fb_rd_row,
	input  logic [PIX_W-1:0]                    fb_rd_data,
	output logic                                frm_valid,
	input  logic                                frm_ready,
	output frame_t                              frm
);

	localparam int ROW_W = (ROWS > 1) ? $clog2(ROWS) : 1;
	localparam logic [IDX_W-1:0] INIT_LAST = IDX_W'(INIT_HEAD + ROWS - 1);
	localparam logic [IDX_W-1:0] REF_LAST  = IDX_W'(ROWS - 1);

	seq_state_t        state_q, state_d;
	logic              refresh_q;
	logic [IDX_W-1:0]  idx_q;
	logic [INT_W-1:0]  intensity_q;
	logic [SCAN_W-1:0] scan_limit_q;
	logic              accept;
	logic              start;
	logic              issue;
	logic              at_last;

	assign accept = in_valid && in_ready;
	assign start  = accept && (func == FUNC_INIT || func == FUNC_REFRESH);
	assign issue  = frm_valid && frm_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			intensity_q  <= INTENSITY_RST;
			scan_limit_q <= SCAN_LIMIT_RST;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_INTENSITY:  intensity_q  <= cfg_data[INT_W-1:0];
				CFG_SCAN_LIMIT: scan_limit_q <= cfg_data[SCAN_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: if (start) state_d = ST_RUN;
			ST_RUN:  if (issue && at_last) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			refresh_q <= 1'b0;
			idx_q     <= '0;
		end else begin
			state_q <= state_d;
			if (start) begin
				refresh_q <= (func == FUNC_REFRESH);
				idx_q     <= '0;
			end else if (issue) begin
				idx_q <= idx_q + 1'b1;
			end
		end
	end

	assign fb_rd_row = idx_q[ROW_W-1:0];
	assign at_last   = refresh_q ? (idx_q == REF_LAST) : (idx_q == INIT_LAST);

	always_comb begin
		in_ready  = 1'b0;
		frm_valid = 1'b0;
		unique case (state_q)
			ST_IDLE: in_ready  = 1'b1;
			ST_RUN:  frm_valid = 1'b1;
			default: ;
		endcase
	end

	// Buffer updates happen in the cycle the word is taken.
	always_comb begin
		fb_wr.en     = accept && (func == FUNC_PIXEL || func == FUNC_LOAD);
		fb_wr.pixel  = (func == FUNC_PIXEL);
		fb_wr.row    = row;
		fb_wr.column = column;
		fb_wr.op     = pixel_op;
		fb_wr.bits   = row_bits;
	end

	always_comb begin
		frm.last = at_last;
		frm.data = '0;
		if (refresh_q) begin
			frm.addr = idx_q + 1'b1;
			frm.data = fb_rd_data;
		end else begin
			frm.addr = idx_q - IDX_W'(INIT_HEAD - 1);
			case (idx_q)
				4'd0: frm.addr = ADDR_DECODE;
				4'd1: begin
					frm.addr = ADDR_INTENSITY;
					frm.data = PIX_W'(intensity_q);
				end
				4'd2: begin
					frm.addr = ADDR_SCANLIM;
					frm.data = PIX_W'(scan_limit_q);
				end
				4'd3: begin
					frm.addr = ADDR_SHUTDOWN;
					frm.data = 8'd1;
				end
				4'd4: frm.addr = ADDR_TEST;
				default: ;
			endcase
		end
	end

endmodule

// File: rtl/lmfd_ser.sv
module lmfd_ser
	import lmfd_pkg::*;
(
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      frm_valid,
	output logic                      frm_ready,
	input  frame_t                    frm,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic [ADDR_W+PIX_W-1:0]   out_data,
	output logic                      out_last
);

	logic [FRAME_W-1:0]      tx_q;
	logic [ADDR_W+PIX_W-1:0] rx_q;
	logic [CNT_W-1:0]        cnt_q;
	logic                    cs_q;
	logic                    done_q;
	logic                    last_q;
	logic                    out_valid_q;
	logic [ADDR_W+PIX_W-1:0] out_data_q;
	logic                    out_last_q;
	logic                    load;
	logic                    move;

	assign frm_ready = !cs_q && !done_q;
	assign load      = frm_valid && frm_ready;
	assign move      = done_q && (!out_valid_q || out_ready);

	// Shift path: the frame leaves most significant bit first under chip
	// select and is collected again at the far end of the line.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cs_q   <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			if (load) begin
				cs_q  <= 1'b1;
				cnt_q <= '0;
			end else if (cs_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(FRAME_W - 1)) begin
					cs_q   <= 1'b0;
					done_q <= 1'b1;
				end
			end
			if (move) done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			tx_q   <= {{(FRAME_W - ADDR_W - PIX_W){1'b0}}, frm.addr, frm.data};
			last_q <= frm.last;
		end else if (cs_q) begin
			tx_q <= {tx_q[FRAME_W-2:0], 1'b0};
			rx_q <= {rx_q[ADDR_W+PIX_W-2:0], tx_q[FRAME_W-1]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (move) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (move) begin
			out_data_q <= {rx_q[PIX_W-1:0], rx_q[ADDR_W+PIX_W-1:PIX_W]};
			out_last_q <= last_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;
	assign out_last  = out_last_q;

	a_idle_count: assert property (@(posedge clk) disable iff (!arst_n)
		!cs_q |-> cnt_q == '0)
		else $error("bit counter running without chip select");

	a_load_select: assert property (@(posedge clk) disable iff (!arst_n)
		load |=> cs_q && !done_q)
		else $error("frame load did not raise chip select");

	a_frame_done: assert property (@(posedge clk) disable iff (!arst_n)
		cs_q && cnt_q == CNT_W'(FRAME_W - 1) |=> done_q && !cs_q)
		else $error("frame did not complete after its last bit");

endmodule
